// ===== rtl/hc08_pkg.sv =====
// ----------------------------------------------------------------------------
// hc08_pkg
// Shared codes, types and control/status bundles for the 68HC08-style ALU.
// ----------------------------------------------------------------------------
package hc08_pkg;

  localparam logic [3:0] ACT_ADD = 4'd0;
  localparam logic [3:0] ACT_ADC = 4'd1;
  localparam logic [3:0] ACT_SUB = 4'd2;
  localparam logic [3:0] ACT_SBC = 4'd3;
  localparam logic [3:0] ACT_AND = 4'd4;
  localparam logic [3:0] ACT_BIT = 4'd5;
  localparam logic [3:0] ACT_ORA = 4'd6;
  localparam logic [3:0] ACT_AIS = 4'd7;
  localparam logic [3:0] ACT_AIX = 4'd8;
  localparam logic [3:0] ACT_INC = 4'd9;
  localparam logic [3:0] ACT_DEC = 4'd10;
  localparam logic [3:0] ACT_NEG = 4'd11;
  localparam logic [3:0] ACT_MUL = 4'd12;
  localparam logic [3:0] ACT_DIV = 4'd13;

  localparam logic [1:0] TGT_ACC = 2'd0;
  localparam logic [1:0] TGT_IDX = 2'd1;

  localparam logic [15:0] SP_RESET  = 16'h00FF;
  localparam logic [7:0]  INC_VTRIP = 8'h7F;
  localparam logic [7:0]  DEC_VTRIP = 8'h80;

  // divider retires two quotient bits per cycle
  localparam int unsigned DIV_STEPS = 8;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic load;      // capture input word
    logic exec;      // single-cycle execute
    logic div_init;  // seed the divider
    logic div_step;  // one divider iteration
  } dp_cmd_t;

  typedef struct packed {
    logic div_go;    // DIV with nonzero divisor pending
    logic div_last;  // final divider iteration
  } dp_stat_t;

endpackage

// ===== rtl/hc08_ctrl.sv =====
// ----------------------------------------------------------------------------
// hc08_ctrl
// Sequencer: accept, execute or run the divider, then hold the result word.
// ----------------------------------------------------------------------------
module hc08_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  hc08_pkg::dp_stat_t stat,
  output hc08_pkg::dp_cmd_t  cmd
);
  import hc08_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (stat.div_go) begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIV;
        end else begin
          cmd.exec   = 1'b1;
          state_next = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/hc08_dpath.sv =====
// ----------------------------------------------------------------------------
// hc08_dpath
// Register file, flags, single-cycle ALU and a radix-4 restoring divider.
// ----------------------------------------------------------------------------
module hc08_dpath (
  input  logic               clk,
  input  logic               rst,
  input  hc08_pkg::dp_cmd_t  cmd,
  output hc08_pkg::dp_stat_t stat,
  input  logic [3:0]         action,
  input  logic [7:0]         operand,
  input  logic [1:0]         target,
  output logic [7:0]         acc_out,
  output logic [7:0]         index_high_out,
  output logic [7:0]         index_low_out,
  output logic [15:0]        stack_out,
  output logic [7:0]         flags_out,
  output logic [7:0]         mem_value,
  output logic               mem_write
);
  import hc08_pkg::*;

  // architectural state
  logic [7:0]  acc, idx_hi, idx_lo;
  logic [15:0] sp;
  logic        fl_v, fl_h, fl_i, fl_n, fl_z, fl_c;
  logic [7:0]  mem_val;
  logic        mem_wr;

  // captured input word
  logic [3:0] act_q;
  logic [7:0] opr_q;
  logic [1:0] tgt_q;

  // divider
  logic [7:0]           div_rem;
  logic [15:0]          div_quo;  // dividend shifts out, quotient shifts in
  logic [DIV_CNT_W-1:0] div_cnt;

  // execute results
  logic [7:0]  acc_next, idx_hi_next, idx_lo_next;
  logic [15:0] sp_next;
  logic        v_next, h_next, n_next, z_next, c_next;
  logic [7:0]  mem_val_next;
  logic        mem_wr_next;

  logic [7:0]  src, rmw_r, logic_r;
  logic [8:0]  sum;
  logic [7:0]  diff;
  logic [15:0] prod, hx_sum, sext_opr;
  logic        cin;
  logic        a7, m7, r7, a3, m3, r3;

  logic [7:0]  rem_a, rem_b;
  logic [15:0] quo_a, quo_b;

  function automatic logic [23:0] div_iter(input logic [7:0] rem, input logic [15:0] quo,
                                           input logic [7:0] dvs);
    logic [8:0] t;
    logic       ge;
    logic [8:0] d;
    t  = {rem, quo[15]};
    ge = (t >= {1'b0, dvs});
    d  = t - {1'b0, dvs};
    return {(ge ? d[7:0] : t[7:0]), quo[14:0], ge};
  endfunction

  assign cin      = fl_c;
  assign sext_opr = {{8{opr_q[7]}}, opr_q};
  assign sum      = {1'b0, acc} + {1'b0, opr_q} + {8'd0, cin & (act_q == ACT_ADC)};
  assign diff     = acc - opr_q - {7'd0, cin & (act_q == ACT_SBC)};
  assign prod     = {8'd0, acc} * {8'd0, idx_lo};
  assign hx_sum   = {idx_hi, idx_lo} + sext_opr;
  assign logic_r  = (act_q == ACT_ORA) ? (acc | opr_q) : (acc & opr_q);

  always_comb begin
    case (tgt_q)
      TGT_ACC: src = acc;
      TGT_IDX: src = idx_lo;
      default: src = opr_q;
    endcase
  end

  always_comb begin
    case (act_q)
      ACT_INC: rmw_r = src + 8'd1;
      ACT_DEC: rmw_r = src - 8'd1;
      default: rmw_r = 8'd0 - src;
    endcase
  end

  assign {rem_a, quo_a} = div_iter(div_rem, div_quo, idx_lo);
  assign {rem_b, quo_b} = div_iter(rem_a, quo_a, idx_lo);

  assign stat.div_go   = (act_q == ACT_DIV) && (idx_lo != 8'd0);
  assign stat.div_last = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));

  always_comb begin
    acc_next     = acc;
    idx_hi_next  = idx_hi;
    idx_lo_next  = idx_lo;
    sp_next      = sp;
    v_next       = fl_v;
    h_next       = fl_h;
    n_next       = fl_n;
    z_next       = fl_z;
    c_next       = fl_c;
    mem_val_next = 8'd0;
    mem_wr_next  = 1'b0;
    a7 = acc[7];
    m7 = opr_q[7];
    a3 = acc[3];
    m3 = opr_q[3];
    r7 = 1'b0;
    r3 = 1'b0;
    unique case (act_q) inside
      ACT_ADD, ACT_ADC: begin
        acc_next = sum[7:0];
        r7 = sum[7];
        r3 = sum[3];
        v_next = (a7 & m7 & ~r7) | (~a7 & ~m7 & r7);
        h_next = (a3 & m3) | (m3 & ~r3) | (~r3 & a3);
        c_next = (a7 & m7) | (m7 & ~r7) | (~r7 & a7);
        n_next = r7;
        z_next = (sum[7:0] == 8'd0);
      end
      ACT_SUB, ACT_SBC: begin
        acc_next = diff;
        r7 = diff[7];
        v_next = (a7 & ~m7 & ~r7) | (~a7 & m7 & r7);
        c_next = (~a7 & m7) | (m7 & r7) | (r7 & ~a7);
        n_next = r7;
        z_next = (diff == 8'd0);
      end
      ACT_AND, ACT_BIT, ACT_ORA: begin
        if (act_q != ACT_BIT) begin
          acc_next = logic_r;
        end
        v_next = 1'b0;
        n_next = logic_r[7];
        z_next = (logic_r == 8'd0);
      end
      ACT_AIS: begin
        sp_next = sp + sext_opr;
      end
      ACT_AIX: begin
        idx_hi_next = hx_sum[15:8];
        idx_lo_next = hx_sum[7:0];
      end
      ACT_INC, ACT_DEC, ACT_NEG: begin
        case (act_q)
          ACT_INC: v_next = (src == INC_VTRIP);
          ACT_DEC: v_next = (src == DEC_VTRIP);
          default: begin
            v_next = src[7] & rmw_r[7];
            c_next = (rmw_r != 8'd0);
          end
        endcase
        n_next = rmw_r[7];
        z_next = (rmw_r == 8'd0);
        case (tgt_q)
          TGT_ACC: acc_next = rmw_r;
          TGT_IDX: idx_lo_next = rmw_r;
          default: begin
            mem_val_next = rmw_r;
            mem_wr_next  = 1'b1;
          end
        endcase
      end
      ACT_MUL: begin
        acc_next    = prod[7:0];
        idx_lo_next = prod[15:8];
        h_next      = 1'b0;
        c_next      = 1'b0;
      end
      ACT_DIV: begin
        // only reached with a zero divisor
        c_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= 8'd0;
      idx_hi  <= 8'd0;
      idx_lo  <= 8'd0;
      sp      <= SP_RESET;
      fl_v    <= 1'b0;
      fl_h    <= 1'b0;
      fl_i    <= 1'b1;
      fl_n    <= 1'b0;
      fl_z    <= 1'b0;
      fl_c    <= 1'b0;
      mem_val <= 8'd0;
      mem_wr  <= 1'b0;
      div_cnt <= '0;
    end else begin
      if (cmd.exec) begin
        acc     <= acc_next;
        idx_hi  <= idx_hi_next;
        idx_lo  <= idx_lo_next;
        sp      <= sp_next;
        fl_v    <= v_next;
        fl_h    <= h_next;
        fl_n    <= n_next;
        fl_z    <= z_next;
        fl_c    <= c_next;
        mem_val <= mem_val_next;
        mem_wr  <= mem_wr_next;
      end
      if (cmd.div_init) begin
        mem_val <= 8'd0;
        mem_wr  <= 1'b0;
        div_cnt <= '0;
      end
      if (cmd.div_step) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
        if (stat.div_last) begin
          acc    <= quo_b[7:0];
          idx_hi <= rem_b;
          fl_c   <= |quo_b[15:8];
          fl_z   <= (quo_b[7:0] == 8'd0);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= action;
      opr_q <= operand;
      tgt_q <= target;
    end
    if (cmd.div_init) begin
      div_rem <= 8'd0;
      div_quo <= {idx_hi, acc};
    end else if (cmd.div_step) begin
      div_rem <= rem_b;
      div_quo <= quo_b;
    end
  end

  assign acc_out        = acc;
  assign index_high_out = idx_hi;
  assign index_low_out  = idx_lo;
  assign stack_out      = sp;
  assign flags_out      = {fl_v, 2'b00, fl_h, fl_i, fl_n, fl_z, fl_c};
  assign mem_value      = mem_val;
  assign mem_write      = mem_wr;

endmodule

// ===== rtl/hc08_arithmetic_logic_unit.sv =====
// ----------------------------------------------------------------------------
// hc08_arithmetic_logic_unit
// 68HC08-style ALU: A, H:X, SP and CCR with one instruction word per request.
// ----------------------------------------------------------------------------
// The result is registered and shown once the execute or the divider loop is done;
// a new word is accepted only after the last result is taken. The divider loop
// retires two quotient bits per cycle.
// Reset: A, H, X cleared, SP = 0x00FF, I set, other flags clear, idle.
module hc08_arithmetic_logic_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  action,
  input  logic [7:0]  operand,
  input  logic [1:0]  target,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  acc_out,
  output logic [7:0]  index_high_out,
  output logic [7:0]  index_low_out,
  output logic [15:0] stack_out,
  output logic [7:0]  flags_out,
  output logic [7:0]  mem_value,
  output logic        mem_write
);
  import hc08_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  hc08_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  hc08_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .action         (action),
    .operand        (operand),
    .target         (target),
    .acc_out        (acc_out),
    .index_high_out (index_high_out),
    .index_low_out  (index_low_out),
    .stack_out      (stack_out),
    .flags_out      (flags_out),
    .mem_value      (mem_value),
    .mem_write      (mem_write)
  );

endmodule

// ===== rtl/hc08_alu_chk.sv =====
// ----------------------------------------------------------------------------
// hc08_alu_chk
// Port-level checks for the ALU, bound onto the top level.
// ----------------------------------------------------------------------------
module hc08_alu_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  acc_out,
  input logic [15:0] stack_out,
  input logic [7:0]  flags_out,
  input logic [7:0]  mem_value,
  input logic        mem_write
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(acc_out) && $stable(stack_out)
      && $stable(flags_out) && $stable(mem_value) && $stable(mem_write))
    else $error("result word changed under stall");

  // one word in flight: no accept while a result is pending
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  // no result word is shown in the cycle after accept
  a_no_early_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !out_valid)
    else $error("result shown in cycle after accept");

  // I is never cleared and unused CCR bits read zero
  a_ccr_fixed: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> flags_out[3] && !flags_out[6] && !flags_out[5])
    else $error("CCR fixed bits wrong");

  a_mem_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !mem_write |-> mem_value == 8'd0)
    else $error("mem_value nonzero without write");

endmodule

bind hc08_arithmetic_logic_unit hc08_alu_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .acc_out   (acc_out),
  .stack_out (stack_out),
  .flags_out (flags_out),
  .mem_value (mem_value),
  .mem_write (mem_write)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 68HC08-style ALU. Instruction words go in
// through a valid/stall channel with random gaps. A cycle-free model of A,
// H:X, SP and the CCR predicts each result word, and the result words are
// compared field by field in arrival order under random output back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import hc08_pkg::*;

  localparam logic [1:0] TGT_MEM = 2'd2;
  localparam logic [1:0] TGT_ALT = 2'd3;  // decodes as memory
  localparam logic [3:0] ACT_RSVD0 = 4'd14;
  localparam logic [3:0] ACT_RSVD1 = 4'd15;

  // CCR bit positions
  localparam int F_V = 7;
  localparam int F_H = 4;
  localparam int F_I = 3;
  localparam int F_N = 2;
  localparam int F_Z = 1;
  localparam int F_C = 0;

  localparam int IDLE_LIMIT = 3000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    logic [7:0]  acc;
    logic [7:0]  xh;
    logic [7:0]  xl;
    logic [15:0] sp;
    logic [7:0]  ccr;
    logic [7:0]  mval;
    logic        mwr;
  } alu_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  action = '0;
  logic [7:0]  operand = '0;
  logic [1:0]  target = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  acc_out;
  logic [7:0]  index_high_out;
  logic [7:0]  index_low_out;
  logic [15:0] stack_out;
  logic [7:0]  flags_out;
  logic [7:0]  mem_value;
  logic        mem_write;

  // architectural state as the bench sees it
  logic [7:0]  model_a;
  logic [7:0]  model_h;
  logic [7:0]  model_x;
  logic [15:0] model_sp;
  logic [7:0]  model_ccr;

  alu_word_t pending_results[$];
  int err_count = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  int stall_run = 0;
  int free_run = 0;
  bit tx_burst = 1'b0;

  hc08_arithmetic_logic_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .action         (action),
    .operand        (operand),
    .target         (target),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .acc_out        (acc_out),
    .index_high_out (index_high_out),
    .index_low_out  (index_low_out),
    .stack_out      (stack_out),
    .flags_out      (flags_out),
    .mem_value      (mem_value),
    .mem_write      (mem_write)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void flag_nz(logic [7:0] r);
    model_ccr[F_N] = r[7];
    model_ccr[F_Z] = (r == 8'h00);
  endfunction

  // executes one instruction on the bench copy of the registers
  function automatic alu_word_t hc08_execute(logic [3:0] act, logic [7:0] m, logic [1:0] tgt);
    alu_word_t res;
    logic [7:0]  a;
    logic [7:0]  r;
    logic [7:0]  src;
    logic [15:0] t;
    logic [15:0] num;
    logic [15:0] q;
    logic [15:0] rem;
    a = model_a;
    res.mval = 8'h00;
    res.mwr = 1'b0;
    src = (tgt == TGT_ACC) ? model_a : (tgt == TGT_IDX) ? model_x : m;
    case (act)
      ACT_ADD, ACT_ADC: begin
        r = a + m + ((act == ACT_ADC) ? {7'd0, model_ccr[F_C]} : 8'd0);
        model_ccr[F_V] = a[7] & m[7] & ~r[7] | ~a[7] & ~m[7] & r[7];
        model_ccr[F_H] = a[3] & m[3] | m[3] & ~r[3] | ~r[3] & a[3];
        model_ccr[F_C] = a[7] & m[7] | m[7] & ~r[7] | ~r[7] & a[7];
        flag_nz(r);
        model_a = r;
      end
      ACT_SUB, ACT_SBC: begin
        r = a - m - ((act == ACT_SBC) ? {7'd0, model_ccr[F_C]} : 8'd0);
        model_ccr[F_V] = a[7] & ~m[7] & ~r[7] | ~a[7] & m[7] & r[7];
        model_ccr[F_C] = ~a[7] & m[7] | m[7] & r[7] | r[7] & ~a[7];
        flag_nz(r);
        model_a = r;
      end
      ACT_AND, ACT_BIT, ACT_ORA: begin
        r = (act == ACT_ORA) ? (a | m) : (a & m);
        if (act != ACT_BIT) model_a = r;
        model_ccr[F_V] = 1'b0;
        flag_nz(r);
      end
      ACT_AIS: model_sp = model_sp + {{8{m[7]}}, m};
      ACT_AIX: {model_h, model_x} = {model_h, model_x} + {{8{m[7]}}, m};
      ACT_INC, ACT_DEC, ACT_NEG: begin
        if (act == ACT_INC) begin
          r = src + 8'd1;
          model_ccr[F_V] = (src == INC_VTRIP);
        end else if (act == ACT_DEC) begin
          r = src - 8'd1;
          model_ccr[F_V] = (src == DEC_VTRIP);
        end else begin
          r = 8'd0 - src;
          model_ccr[F_V] = src[7] & r[7];
          model_ccr[F_C] = (r != 8'h00);
        end
        flag_nz(r);
        if (tgt == TGT_ACC) begin
          model_a = r;
        end else if (tgt == TGT_IDX) begin
          model_x = r;
        end else begin
          res.mval = r;
          res.mwr = 1'b1;
        end
      end
      ACT_MUL: begin
        t = {8'd0, model_a} * {8'd0, model_x};
        model_a = t[7:0];
        model_x = t[15:8];
        model_ccr[F_H] = 1'b0;
        model_ccr[F_C] = 1'b0;
      end
      ACT_DIV: begin
        if (model_x == 8'h00) begin
          model_ccr[F_C] = 1'b1;
        end else begin
          num = {model_h, model_a};
          q = num / {8'd0, model_x};
          rem = num % {8'd0, model_x};
          model_a = q[7:0];
          model_h = rem[7:0];
          model_ccr[F_C] = (q > 16'h00FF);
          model_ccr[F_Z] = (q[7:0] == 8'h00);
        end
      end
      default: ;
    endcase
    res.acc = model_a;
    res.xh = model_h;
    res.xl = model_x;
    res.sp = model_sp;
    res.ccr = model_ccr & 8'h9F;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    $display("ERROR @%0t %s: got %h, expected %h", $time, what, got, exp_val);
    err_count++;
  endtask

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] exp_val);
    if (got !== exp_val) report_mismatch(what, got, exp_val);
  endtask

  // offers one instruction word and records its prediction once accepted
  task automatic issue_instr(input logic [3:0] act, input logic [7:0] opnd,
                             input logic [1:0] tgt);
    int gap;
    gap = tx_burst ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    action <= act;
    operand <= opnd;
    target <= tgt;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(hc08_execute(act, opnd, tgt));
  endtask

  task automatic issue_random_instr();
    logic [3:0] act;
    logic [7:0] opnd;
    int roll;
    act = ($urandom_range(0, 49) == 0) ? 4'($urandom_range(14, 15))
                                        : 4'($urandom_range(0, 13));
    roll = $urandom_range(0, 9);
    case (roll)
      0: opnd = 8'h00;
      1: opnd = 8'hFF;
      2: opnd = 8'h7F;
      3: opnd = 8'h80;
      default: opnd = 8'($urandom);
    endcase
    issue_instr(act, opnd, 2'($urandom_range(0, 3)));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    issue_instr(ACT_DIV, 8'h00, TGT_ACC);    // X is zero after reset
    issue_instr(ACT_ADD, 8'h7F, TGT_ACC);
    issue_instr(ACT_ADD, 8'h01, TGT_ACC);    // signed overflow, half carry
    issue_instr(ACT_ADD, 8'h80, TGT_ACC);    // wraps to zero with carry
    issue_instr(ACT_ADC, 8'hFF, TGT_ACC);
    issue_instr(ACT_SUB, 8'h01, TGT_ACC);
    issue_instr(ACT_SBC, 8'h80, TGT_ACC);
    issue_instr(ACT_AND, 8'h00, TGT_ACC);
    issue_instr(ACT_ORA, 8'hFF, TGT_ACC);
    issue_instr(ACT_BIT, 8'h80, TGT_ACC);
    issue_instr(ACT_AIS, 8'h80, TGT_ACC);    // negative immediate
    issue_instr(ACT_AIS, 8'h7F, TGT_ACC);
    issue_instr(ACT_AIX, 8'hFF, TGT_ACC);    // H:X wraps below zero
    issue_instr(ACT_AIX, 8'h05, TGT_ACC);
    issue_instr(ACT_INC, 8'h7F, TGT_MEM);
    issue_instr(ACT_DEC, 8'h80, TGT_MEM);
    issue_instr(ACT_NEG, 8'h80, TGT_ALT);    // 0x80 negates to itself
    issue_instr(ACT_NEG, 8'h00, TGT_MEM);
    issue_instr(ACT_INC, 8'hFF, TGT_IDX);
    issue_instr(ACT_DEC, 8'h00, TGT_ACC);
    issue_instr(ACT_NEG, 8'h00, TGT_ACC);
    issue_instr(ACT_MUL, 8'h00, TGT_ACC);
    issue_instr(ACT_DIV, 8'h00, TGT_ACC);
    issue_instr(ACT_RSVD0, 8'hFF, TGT_ALT);
    issue_instr(ACT_RSVD1, 8'h00, TGT_MEM);
  endtask

  task automatic test_random();
    for (int i = 0; i < 1050; i++) begin
      if (i % 100 == 0) tx_burst = ($urandom_range(0, 2) == 0);
      issue_random_instr();
    end
    tx_burst = 1'b0;
  endtask

  // output held off while input keeps coming, so the block backs up
  task automatic test_backpressure();
    wait_drained();
    hold_cycles = LONG_HOLD;
    tx_burst = 1'b1;
    repeat (40) issue_random_instr();
    tx_burst = 1'b0;
  endtask

  task automatic test_drain_pause();
    repeat (8) begin
      repeat (5) issue_random_instr();
      wait_drained();
      repeat ($urandom_range(5, 20)) @(posedge clk);
    end
  endtask

  // output side: random stall runs, plus the long hold when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_stall <= 1'b1;
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if (free_run > 0) begin
      free_run--;
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
      stall_run = pick_gap();
      free_run = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                              : $urandom_range(0, 4);
    end
  end

  always @(posedge clk) begin
    alu_word_t exp_word;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", {8'h00, acc_out}, 16'h0000);
      end else begin
        exp_word = pending_results.pop_front();
        check_field("acc_out", 16'(acc_out), 16'(exp_word.acc));
        check_field("index_high_out", 16'(index_high_out), 16'(exp_word.xh));
        check_field("index_low_out", 16'(index_low_out), 16'(exp_word.xl));
        check_field("stack_out", stack_out, exp_word.sp);
        check_field("flags_out", 16'(flags_out), 16'(exp_word.ccr));
        check_field("mem_value", 16'(mem_value), 16'(exp_word.mval));
        check_field("mem_write", 16'(mem_write), 16'(exp_word.mwr));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    model_a = 8'h00;
    model_h = 8'h00;
    model_x = 8'h00;
    model_sp = SP_RESET;
    model_ccr = 8'h00;
    model_ccr[F_I] = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    wait_drained();
    test_random();
    test_backpressure();
    test_drain_pause();
    wait_drained();
    repeat (30) @(posedge clk);

    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
